@@ design/gtag_pkg.sv @@
// Shared types, register indexes and the GF(2^128) multiply for the GHASH tag engine.
// No dependencies; imported by every design module except gtag_checker.
`default_nettype none

package gtag_pkg;

   localparam int BLOCK_W  = 128;
   localparam int HALF_W   = 64;
   localparam int CSR_AW   = 2;
   localparam int TAGB_W   = 5;
   localparam int TAG_BYTES_MAX = 16;

   // configuration register indexes
   localparam logic [CSR_AW-1:0] CSR_HASH_KEY_HI = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_HASH_KEY_LO = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_TAG_BYTES   = 2'd2;

   localparam logic [TAGB_W-1:0] TAG_BYTES_RESET = 5'd16;

   // one block item, halves joined as {hi, lo}
   typedef struct packed {
      logic [BLOCK_W-1:0] block;
      logic               first;
      logic               last;
      logic [BLOCK_W-1:0] mask;
      logic [BLOCK_W-1:0] expect_tag;
   } item_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic vld;
   } qstat_type;

   // GCM multiply: bit 127 of the word is the x^0 coefficient (reflected order),
   // reduction by x^128 + x^7 + x^2 + x + 1.
   function automatic logic [BLOCK_W-1:0] gcm_field_mul(input logic [BLOCK_W-1:0] a,
                                                        input logic [BLOCK_W-1:0] b);
      logic [2*BLOCK_W-2:0] p;
      logic [133:0]         t;
      logic [12:0]          u;
      logic [BLOCK_W-1:0]   low;
      logic [BLOCK_W-1:0]   r;
      p = '0;
      // carry-less product, each output bit an independent XOR tree
      for (int i = 0; i < BLOCK_W; i++) begin
         for (int j = 0; j < BLOCK_W; j++) begin
            p[i+j] = p[i+j] ^ (a[BLOCK_W-1-i] & b[BLOCK_W-1-j]);
         end
      end
      // first fold of the upper 127 coefficients
      t = {7'd0, p[254:128]} ^ {6'd0, p[254:128], 1'b0} ^
          {5'd0, p[254:128], 2'b0} ^ {p[254:128], 7'b0};
      // second fold of the few bits that spill over degree 127
      u = {7'd0, t[133:128]} ^ {6'd0, t[133:128], 1'b0} ^
          {5'd0, t[133:128], 2'b0} ^ {t[133:128], 7'b0};
      low = p[127:0] ^ t[127:0] ^ {115'd0, u};
      for (int k = 0; k < BLOCK_W; k++) begin
         r[k] = low[BLOCK_W-1-k];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/gtag_front.sv @@
// Front end: input register that accepts items and sorts out their fields.
// Depends on gtag_pkg.
`default_nettype none

module gtag_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic [383:0]        req_tdata,   // block_hi, block_lo, mask_hi, mask_lo,
                                                 // expect_hi, expect_lo
   input  wire logic                req_tlast,   // last_block
   input  wire logic [0:0]          req_tuser,   // first_block
   input  wire gtag_pkg::qstat_type q_stat,
   output      logic                push,
   output      gtag_pkg::item_type  push_item
);
   import gtag_pkg::*;

   logic     vld_ff, vld_in;
   item_type item_ff, item_in;
   logic     take;

   // ready whenever the holding register is empty or moving on
   assign push       = vld_ff & ~q_stat.full;
   assign req_tready = ~vld_ff | ~q_stat.full;
   assign take       = req_tvalid & req_tready;
   assign push_item  = item_ff;

   // unpack the bus into an item
   always_comb begin
      item_in            = item_ff;
      if (take) begin
         item_in.block      = {req_tdata[63:0],    req_tdata[127:64]};
         item_in.mask       = {req_tdata[191:128], req_tdata[255:192]};
         item_in.expect_tag = {req_tdata[319:256], req_tdata[383:320]};
         item_in.first      = req_tuser[0];
         item_in.last       = req_tlast;
      end
      vld_in = take | (vld_ff & ~push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

@@ design/gtag_queue.sv @@
// Two-entry item queue between the front end and the hash back end.
// Depends on gtag_pkg.
`default_nettype none

module gtag_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire gtag_pkg::item_type  push_item,
   input  wire logic                pop,
   output      gtag_pkg::qstat_type q_stat,
   output      gtag_pkg::item_type  head_item
);
   import gtag_pkg::*;

   item_type   mem_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign q_stat.full = (cnt_ff == 2'd2);
   assign q_stat.vld  = (cnt_ff != 2'd0);
   assign head_item   = mem_ff[rptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ design/gtag_back.sv @@
// Back end: hash key registers, GHASH accumulator, tag stage and output register.
// Depends on gtag_pkg (gcm_field_mul, item_type, register indexes).
`default_nettype none

module gtag_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [gtag_pkg::CSR_AW-1:0] csr_addr,
   input  wire logic [63:0]              csr_wdata,
   input  wire gtag_pkg::qstat_type      q_stat,
   input  wire gtag_pkg::item_type       head_item,
   output      logic                     pop,
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic [127:0]             rsp_tdata,   // tag_hi, tag_lo
   output      logic [0:0]               rsp_tuser    // tag_match
);
   import gtag_pkg::*;

   logic [BLOCK_W-1:0] hkey_ff, hkey_in;
   logic [TAGB_W-1:0]  tagb_ff, tagb_in;
   logic [BLOCK_W-1:0] acc_ff, acc_in;
   logic [BLOCK_W-1:0] prod;
   logic               res_vld_ff, res_vld_in;
   logic [BLOCK_W-1:0] res_tag_ff, res_tag_in;
   logic [BLOCK_W-1:0] res_exp_ff, res_exp_in;
   logic               out_vld_ff, out_vld_in;
   logic [BLOCK_W-1:0] out_tag_ff, out_tag_in;
   logic               out_match_ff, out_match_in;
   logic               out_free, res_adv;
   logic [BLOCK_W-1:0] diff;
   logic [TAGB_W-1:0]  nbytes;
   logic               miss;

   // configuration writes
   always_comb begin
      hkey_in = hkey_ff;
      tagb_in = tagb_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_HASH_KEY_HI: hkey_in[127:64] = csr_wdata;
            CSR_HASH_KEY_LO: hkey_in[63:0]   = csr_wdata;
            CSR_TAG_BYTES:   tagb_in         = csr_wdata[TAGB_W-1:0];
            default:         ;
         endcase
      end
   end

   // handshake between the queue head, the tag stage and the output register
   assign out_free = ~out_vld_ff | rsp_tready;
   assign res_adv  = res_vld_ff & out_free;
   assign pop      = q_stat.vld & (~head_item.last | ~res_vld_ff | res_adv);

   // absorb one block per cycle while the queue holds an item and a last block is not held back by a full tag stage
   assign prod = gcm_field_mul((head_item.first ? '0 : acc_ff) ^ head_item.block, hkey_ff);

   always_comb begin
      acc_in     = pop ? prod : acc_ff;
      res_vld_in = (pop & head_item.last) | (res_vld_ff & ~res_adv);
      res_tag_in = res_tag_ff;
      res_exp_in = res_exp_ff;
      if (pop & head_item.last) begin
         res_tag_in = prod ^ head_item.mask;
         res_exp_in = head_item.expect_tag;
      end
   end

   // compare leading bytes, most significant first
   always_comb begin
      diff   = res_tag_ff ^ res_exp_ff;
      nbytes = (tagb_ff > TAGB_W'(TAG_BYTES_MAX)) ? TAGB_W'(TAG_BYTES_MAX) : tagb_ff;
      miss   = 1'b0;
      for (int b = 0; b < TAG_BYTES_MAX; b++) begin
         if (TAGB_W'(b) < nbytes) begin
            miss = miss | (|diff[BLOCK_W-1-8*b -: 8]);
         end
      end
   end

   // output register
   always_comb begin
      out_vld_in   = res_adv | (out_vld_ff & ~rsp_tready);
      out_tag_in   = res_adv ? res_tag_ff : out_tag_ff;
      out_match_in = res_adv ? ~miss : out_match_ff;
   end

   assign rsp_tvalid   = out_vld_ff;
   assign rsp_tdata    = {out_tag_ff[63:0], out_tag_ff[127:64]};
   assign rsp_tuser[0] = out_match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hkey_ff    <= '0;
         tagb_ff    <= TAG_BYTES_RESET;
         acc_ff     <= '0;
         res_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         hkey_ff    <= hkey_in;
         tagb_ff    <= tagb_in;
         acc_ff     <= acc_in;
         res_vld_ff <= res_vld_in;
         out_vld_ff <= out_vld_in;
      end
      res_tag_ff   <= res_tag_in;
      res_exp_ff   <= res_exp_in;
      out_tag_ff   <= out_tag_in;
      out_match_ff <= out_match_in;
   end

endmodule

`default_nettype wire

@@ design/ghash_tag_engine_core.sv @@
// GHASH tag engine: an accepted item passes the input register, the queue, the
// GF(2^128) multiply stage and the output register, in that order; rsp_tvalid
// rises once the result reaches the output register.
// Throughput 1 item per cycle while rsp_tready does not stall the output; the
// accumulator loop through one full combinational GF multiply sets that figure.
// Reset is synchronous, active high: empties all stages, clears the
// accumulator and hash key, sets tag_bytes to 16.
`default_nettype none

module ghash_tag_engine_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   input  wire logic [383:0]                req_tdata,  // block_hi, block_lo, mask_hi,
                                                        // mask_lo, expect_hi, expect_lo
   input  wire logic                        req_tlast,  // last_block
   input  wire logic [0:0]                  req_tuser,  // first_block
   output      logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   output      logic [127:0]                rsp_tdata,  // tag_hi, tag_lo
   output      logic [0:0]                  rsp_tuser,  // tag_match
   input  wire logic                        csr_we,
   input  wire logic [gtag_pkg::CSR_AW-1:0] csr_addr,
   input  wire logic [63:0]                 csr_wdata
);
   import gtag_pkg::*;

   qstat_type q_stat;
   logic      push, pop;
   item_type  push_item, head_item;

   gtag_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .push       (push),
      .push_item  (push_item)
   );

   gtag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .q_stat    (q_stat),
      .head_item (head_item)
   );

   gtag_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_stat     (q_stat),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ design/gtag_checker.sv @@
// Port-level checks for the GHASH tag engine, bound to the top level.
// Self-contained; needs no package.
`default_nettype none

module gtag_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tready,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [127:0]                rsp_tdata,
   input wire logic [0:0]                  rsp_tuser
);

   // reset empties the output stage
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // front register is free right after reset
   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("req_tready low after reset");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its tag and match flag
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

endmodule

bind ghash_tag_engine_core gtag_checker u_gtag_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ghash_tag_engine_core: GHASH blocks in, tag and match flag out.
// Depends on gtag_pkg for register indexes and widths and on the engine under test.

module tb_top;
   import gtag_pkg::*;

   localparam int          CYCLE_LIMIT = 400000;
   localparam int          ITEMS_PER_PHASE = 150;
   localparam logic [CSR_AW-1:0] CSR_SPARE = 2'd3;    // unmapped index, must be ignored
   localparam logic [127:0] GF_ONE = {1'b1, 127'd0};  // H = 1 in GCM bit order

   // how the current hash key lets the generator know the tag in advance
   typedef enum {KEY_ZERO, KEY_UNIT, KEY_OTHER} key_kind_type;

   typedef struct {
      logic [127:0] blk;    // {block_hi, block_lo}
      logic         is_first;
      logic         is_last;
      logic [127:0] mask;   // {mask_hi, mask_lo}
      logic [127:0] expt;   // {expect_hi, expect_lo}
   } blk_item_type;

   typedef struct {
      logic [127:0] tag;    // {tag_hi, tag_lo}
      logic         match;
   } tag_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [383:0]        req_tdata = '0;  // block_hi, block_lo, mask_hi, mask_lo,
                                         // expect_hi, expect_lo
   logic                req_tlast = 1'b0; // last_block
   logic [0:0]          req_tuser = '0;   // first_block
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [127:0]        rsp_tdata;        // tag_hi, tag_lo
   logic [0:0]          rsp_tuser;        // tag_match
   logic                csr_we = 1'b0;
   logic [CSR_AW-1:0]   csr_addr = '0;
   logic [63:0]         csr_wdata = '0;

   ghash_tag_engine_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: register copies and the running GHASH digest
   logic [127:0]        hash_key = '0;
   logic [TAGB_W-1:0]   cfg_tag_bytes = TAG_BYTES_RESET;
   logic [127:0]        digest = '0;

   blk_item_type        block_fifo[$];
   tag_result_type      tag_expect_q[$];
   blk_item_type        bus_item;

   int                  items_taken = 0;
   int                  gap_left = 0;
   int                  stall_left = 0;
   int                  hold_left = 0;
   int                  next_hold_at = 400;
   int                  cycle_count = 0;
   int                  fail_count = 0;
   bit                  tx_gaps = 1'b0;
   bit                  rx_stalls = 1'b0;

   // generator-side knowledge used to aim expected tags near the real one
   key_kind_type        key_kind = KEY_ZERO;
   logic [127:0]        gen_digest = '0;
   bit                  gen_digest_ok = 1'b0;

   // GF(2^128) multiply, bit 127 of the word is the x^0 coefficient
   function automatic logic [127:0] gcm_mult(logic [127:0] x, logic [127:0] h);
      logic [127:0] z;
      logic [127:0] v;
      logic         carry;
      z = '0;
      v = h;
      for (int i = 0; i < 128; i++) begin
         if (x[127-i]) z = z ^ v;
         carry = v[0];
         v = v >> 1;
         if (carry) v[127:120] = v[127:120] ^ 8'hE1;
      end
      return z;
   endfunction

   // fold one accepted block into the digest; a last block yields a tag
   function automatic void absorb_block(blk_item_type it);
      logic [127:0]   t;
      logic [127:0]   cmp_mask;
      int unsigned    n;
      tag_result_type r;
      if (it.is_first) digest = '0;
      digest = gcm_mult(digest ^ it.blk, hash_key);
      if (!it.is_last) return;
      t = digest ^ it.mask;
      n = (cfg_tag_bytes > 16) ? 16 : cfg_tag_bytes;
      cmp_mask = (n == 0) ? '0 : (~128'd0 << (128 - 8 * n));
      r.tag = t;
      r.match = (((t ^ it.expt) & cmp_mask) == '0);
      tag_expect_q.push_back(r);
   endfunction

   function automatic logic [63:0] rand64();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [127:0] rand128();
      return {rand64(), rand64()};
   endfunction

   // half the time a clean expected tag, else one bit flipped somewhere
   function automatic logic [127:0] pick_flip();
      if ($urandom_range(0, 1) == 0) return '0;
      return 128'd1 << $urandom_range(0, 127);
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      if (!tx_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic int pick_stall();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   function automatic int msg_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(9, 16);
   endfunction

   // queue one item; expected tag is built from what the generator can know
   function automatic void queue_block(logic [127:0] blk, bit is_first, bit is_last,
                                       logic [127:0] mask, logic [127:0] flip);
      blk_item_type it;
      logic [127:0] base;
      if (is_first) begin
         gen_digest = '0;
         gen_digest_ok = 1'b1;
      end
      gen_digest = gen_digest ^ blk;
      case (key_kind)
         KEY_ZERO: base = mask;
         KEY_UNIT: base = gen_digest_ok ? (gen_digest ^ mask) : rand128();
         default:  base = rand128();
      endcase
      it.blk = blk;
      it.is_first = is_first;
      it.is_last = is_last;
      it.mask = mask;
      it.expt = base ^ flip;
      block_fifo.push_back(it);
   endfunction

   task automatic write_csr(logic [CSR_AW-1:0] addr, logic [63:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      case (addr)
         CSR_HASH_KEY_HI: hash_key[127:64] = data;
         CSR_HASH_KEY_LO: hash_key[63:0] = data;
         CSR_TAG_BYTES:   cfg_tag_bytes = data[TAGB_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_hash_key(logic [127:0] key, key_kind_type kind);
      write_csr(CSR_HASH_KEY_HI, key[127:64]);
      write_csr(CSR_HASH_KEY_LO, key[63:0]);
      key_kind = kind;
      gen_digest_ok = 1'b0;
   endtask

   task automatic set_tag_bytes(int unsigned n);
      write_csr(CSR_TAG_BYTES, 64'(n));
   endtask

   // wait until every item is taken and every tag is back, then let the pipe empty
   task automatic drain_and_settle();
      while (block_fifo.size() != 0 || req_tvalid || tag_expect_q.size() != 0)
         @(negedge clock);
      repeat (12) @(posedge clock);
   endtask

   // item driver: presents queued items with random gaps between them
   always @(posedge clock) begin : req_driver
      blk_item_type nxt;
      bit           take;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else begin
         take = req_tvalid && req_tready;
         if (take) begin
            absorb_block(bus_item);
            items_taken <= items_taken + 1;
         end
         if (!req_tvalid || take) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (block_fifo.size() != 0) begin
               nxt = block_fifo.pop_front();
               bus_item <= nxt;
               req_tdata <= {nxt.expt[63:0], nxt.expt[127:64], nxt.mask[63:0],
                             nxt.mask[127:64], nxt.blk[63:0], nxt.blk[127:64]};
               req_tlast <= nxt.is_last;
               req_tuser <= nxt.is_first;
               req_tvalid <= 1'b1;
               gap_left <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the block backs up and stalls its input
   always @(posedge clock) begin : rsp_hold
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (items_taken >= next_hold_at) begin
         hold_left <= 250;
         next_hold_at <= next_hold_at + 500;
      end
   end

   // tag monitor: random stalls, compares each tag with the oldest expected one
   always @(posedge clock) begin : rsp_monitor
      tag_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (tag_expect_q.size() == 0) begin
               $error("unexpected tag item: tag_hi=%h tag_lo=%h tag_match=%b",
                      rsp_tdata[63:0], rsp_tdata[127:64], rsp_tuser[0]);
               fail_count = fail_count + 1;
            end else begin
               want = tag_expect_q.pop_front();
               if (rsp_tdata[63:0] !== want.tag[127:64]) begin
                  $error("tag_hi: expected %h, got %h", want.tag[127:64], rsp_tdata[63:0]);
                  fail_count = fail_count + 1;
               end
               if (rsp_tdata[127:64] !== want.tag[63:0]) begin
                  $error("tag_lo: expected %h, got %h", want.tag[63:0], rsp_tdata[127:64]);
                  fail_count = fail_count + 1;
               end
               if (rsp_tuser[0] !== want.match) begin
                  $error("tag_match: expected %b, got %b", want.match, rsp_tuser[0]);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (rx_stalls && $urandom_range(0, 99) < 20) begin
            stall_left <= pick_stall();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned tb_list[8];
      int          sent;
      int          len;
      logic [127:0] b;
      tb_list = '{16, 1, 0, 31, 8, 9, 17, 0};
      tb_list[7] = $urandom_range(0, 31);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset values: key is zero, so the tag is just the mask
      queue_block('0, 1, 1, '0, '0);
      queue_block('1, 1, 1, '1, '0);
      queue_block(rand128(), 0, 0, rand128(), '0);
      queue_block(rand128(), 0, 1, rand128(), 128'd1);
      drain_and_settle();

      // H = 1: digest is the XOR of the message blocks
      set_hash_key(GF_ONE, KEY_UNIT);
      queue_block('1, 1, 0, rand128(), '0);
      queue_block('0, 0, 0, rand128(), '0);
      queue_block(rand128(), 0, 1, rand128(), '0);
      b = rand128();
      queue_block(b, 1, 1, rand128(), 128'd1);      // last byte differs: mismatch
      drain_and_settle();
      set_tag_bytes(15);
      queue_block(b, 1, 1, rand128(), 128'd1);      // last byte not compared
      queue_block(b, 1, 1, rand128(), 128'd1 << 8); // byte 14 compared
      drain_and_settle();
      set_tag_bytes(1);
      queue_block(b, 1, 1, rand128(), 128'd1 << 119);
      queue_block(b, 1, 1, rand128(), 128'd1 << 127);
      drain_and_settle();
      set_tag_bytes(0);                              // nothing compared
      queue_block(b, 1, 1, rand128(), 128'd1 << 127);
      drain_and_settle();
      set_tag_bytes(31);                             // saturates to 16
      queue_block(b, 1, 1, rand128(), 128'd1);
      drain_and_settle();
      set_tag_bytes(8);
      queue_block(b, 1, 1, rand128(), 128'd1 << 64);
      queue_block(b, 1, 1, rand128(), 128'd1 << 63);
      drain_and_settle();

      // all-ones key; message continued without a first block
      set_hash_key('1, KEY_OTHER);
      write_csr(CSR_SPARE, '1);
      set_tag_bytes(16);
      queue_block('1, 0, 1, '1, '0);
      queue_block('1, 1, 0, '0, '0);
      queue_block('0, 0, 1, '0, '0);
      drain_and_settle();

      // random phases over key kinds and tag lengths
      for (int p = 0; p < 8; p++) begin
         drain_and_settle();
         case (p % 3)
            0: set_hash_key('0, KEY_ZERO);
            1: set_hash_key(GF_ONE, KEY_UNIT);
            default: set_hash_key((p == 2) ? '1 : rand128(), KEY_OTHER);
         endcase
         set_tag_bytes(tb_list[p]);
         tx_gaps = (p != 2 && p != 5);
         rx_stalls = (p != 4 && p != 5);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 80) begin
               len = msg_len();
               for (int k = 0; k < len; k++)
                  queue_block(rand128(), k == 0, k == len - 1, rand128(), pick_flip());
               sent = sent + len;
            end else begin
               // stray item with arbitrary framing
               queue_block(rand128(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           rand128(), pick_flip());
               sent = sent + 1;
            end
         end
      end
      drain_and_settle();

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
